>>> design/assert_macros.svh
// Assertion macros used by adcbd_eval.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ADCBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that must also hold during reset.
`define ADCBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> design/adcbd_pkg.sv
package adcbd_pkg;

    // Default widths of the sample and of the time-in-state counter.
    localparam int ADC_BITS_DEF  = 12;
    localparam int TIME_BITS_DEF = 20;

    // Width of the debounce count and of the change counter.
    localparam int DBNC_BITS = 4;

    // Register reset values.
    localparam int RST_PRESSED_THR  = 3000;
    localparam int RST_RELEASED_THR = 500;
    localparam int RST_DEBOUNCE     = 5;
    localparam int RST_STUCK_LIMIT  = 30000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PRESSED_THR  = 2'd0,
        CFG_RELEASED_THR = 2'd1,
        CFG_DEBOUNCE     = 2'd2,
        CFG_STUCK_LIMIT  = 2'd3
    } t_cfg_idx;

    // Event codes carried with each result.
    typedef enum logic [2:0] {
        EV_NONE           = 3'd0,
        EV_OFF_TO_ON      = 3'd1,
        EV_ON_TO_OFF      = 3'd2,
        EV_STUCK_PRESSED  = 3'd3,
        EV_STUCK_RELEASED = 3'd4
    } t_event;

    // Reported button state.
    typedef enum logic [1:0] {
        ST_UNKNOWN  = 2'd0,
        ST_RELEASED = 2'd1,
        ST_PRESSED  = 2'd2
    } t_rep_state;

    // One result as held in the output register.
    typedef struct packed {
        t_event     event_code;
        t_rep_state reported_state;
        logic       stuck_now;
    } t_result;

endpackage

>>> design/adcbd_sample_if.sv
interface adcbd_sample_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> design/adcbd_result_if.sv
interface adcbd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [1:0] reported_state;
    logic       stuck_now;

    modport source (output valid, output event_code, output reported_state,
                    output stuck_now, input ready);
    modport sink   (input valid, input event_code, input reported_state,
                    input stuck_now, output ready);
endinterface

>>> design/adcbd_in_reg.sv
module adcbd_in_reg #(
    parameter int ADC_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    adcbd_sample_if.sink        i_sample,
    input  logic                i_take,
    output logic                o_valid,
    output logic [ADC_BITS-1:0] o_sample
);
    import adcbd_pkg::*;

    logic                r_valid;
    logic [ADC_BITS-1:0] r_sample;

    // The register can load whenever it is empty or its sample moves on.
    assign i_sample.ready = !r_valid || i_take;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_valid <= i_sample.valid;
        end
    end

    // Sample payload; loaded on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_sample <= i_sample.adc_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
endmodule

>>> design/adcbd_eval.sv
`include "assert_macros.svh"

module adcbd_eval #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [ADC_BITS-1:0]                 i_sample,
    input  logic [ADC_BITS-1:0]                 i_pressed_thr,
    input  logic [ADC_BITS-1:0]                 i_released_thr,
    input  logic [adcbd_pkg::DBNC_BITS-1:0]     i_debounce,
    input  logic [TIME_BITS-1:0]                i_stuck_limit,
    output logic                                o_take,
    adcbd_result_if.source                      o_result
);
    import adcbd_pkg::*;

    localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

    // Debounce state.
    logic                 r_pressed;
    logic [DBNC_BITS-1:0] r_change_cnt;
    logic [TIME_BITS-1:0] r_ticks;
    logic                 r_stuck;

    // Output register.
    logic    r_out_valid;
    t_result r_res;

    logic                 n_pressed;
    logic [DBNC_BITS-1:0] n_change_cnt;
    logic [TIME_BITS-1:0] n_ticks;
    logic                 n_stuck;
    t_result              n_res;

    logic                 take;
    logic                 is_pressed;
    logic                 is_released;
    logic [DBNC_BITS-1:0] cnt_inc;

    // The sample moves on when the output register is free or being emptied.
    assign take   = i_valid && (!r_out_valid || o_result.ready);
    assign o_take = take;

    // Classify the sample and work out the next state and the result.
    always_comb begin
        is_pressed  = i_sample >= i_pressed_thr;
        is_released = i_sample <= i_released_thr;
        cnt_inc     = (r_change_cnt < i_debounce) ? r_change_cnt + 1'b1 : r_change_cnt;

        n_pressed          = r_pressed;
        n_change_cnt       = r_change_cnt;
        n_ticks            = r_ticks;
        n_stuck            = r_stuck;
        n_res.event_code   = EV_NONE;

        if (is_pressed || is_released) begin
            if (is_pressed == r_pressed) begin
                n_change_cnt = '0;
                if (r_ticks != TimeMax) begin
                    n_ticks = r_ticks + 1'b1;
                end
            end else begin
                n_ticks = '0;
                if (cnt_inc >= i_debounce) begin
                    // Enough differing samples: commit the new state.
                    n_pressed        = is_pressed;
                    n_change_cnt     = '0;
                    n_stuck          = 1'b0;
                    n_res.event_code = is_pressed ? EV_OFF_TO_ON : EV_ON_TO_OFF;
                end else begin
                    n_change_cnt = cnt_inc;
                end
            end
        end

        // Stuck check runs on every sample, including band readings.
        if (!n_stuck && (n_ticks >= i_stuck_limit)) begin
            n_stuck          = 1'b1;
            n_res.event_code = n_pressed ? EV_STUCK_PRESSED : EV_STUCK_RELEASED;
        end

        n_res.stuck_now      = n_stuck;
        n_res.reported_state = n_stuck ? ST_UNKNOWN :
                               (n_pressed ? ST_PRESSED : ST_RELEASED);
    end

    // State registers advance once per sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= 1'b0;
            r_change_cnt <= '0;
            r_ticks      <= '0;
            r_stuck      <= 1'b0;
        end else if (take) begin
            r_pressed    <= n_pressed;
            r_change_cnt <= n_change_cnt;
            r_ticks      <= n_ticks;
            r_stuck      <= n_stuck;
        end
    end

    // Output valid: set by a new result, cleared when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.event_code     = r_res.event_code;
    assign o_result.reported_state = r_res.reported_state;
    assign o_result.stuck_now      = r_res.stuck_now;

    // A committed edge leaves both counters and the stuck flag cleared.
    `ADCBD_ASSERT(a_edge_clears, i_clk, i_rst_n, (take && (n_res.event_code == EV_OFF_TO_ON || n_res.event_code == EV_ON_TO_OFF)) |=> (r_change_cnt == '0 && r_ticks == '0 && !r_stuck), "edge commit did not clear the state")
    // The stuck flag is only ever raised together with a stuck event.
    `ADCBD_ASSERT(a_stuck_event, i_clk, i_rst_n, $rose(r_stuck) |-> (r_res.event_code == EV_STUCK_PRESSED || r_res.event_code == EV_STUCK_RELEASED), "stuck flag raised without a stuck event")
    // The reported state is unknown exactly while stuck.
    `ADCBD_ASSERT(a_unknown_iff_stuck, i_clk, i_rst_n, r_out_valid |-> (r_res.stuck_now == (r_res.reported_state == ST_UNKNOWN)), "reported state disagrees with stuck flag")
    // Without a sample the time counter holds.
    `ADCBD_ASSERT(a_ticks_hold, i_clk, i_rst_n, !take |=> $stable(r_ticks), "time counter moved without a sample")
endmodule

>>> design/adc_button_debounce_stuck_detect.sv
// Debounced push button read through an ADC, with stuck detection.
// Samples arrive on i_sample (valid/ready, one ADC conversion per
// transaction); every sample yields exactly one result on o_result carrying
// an event code, the reported state and the stuck flag.
// Thresholds, debounce count and stuck limit are written through the plain
// write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user is to write them
// only while the block is idle, which the block itself does not enforce.
// Each accepted sample loads the input register, and its result the result
// register when it moves on. Throughput: one sample per cycle unless the
// receiver stalls, set by the combinational state update in between.
// While the receiver stalls, the finished result is held and one more
// sample can wait in the input register; i_sample.ready then drops until
// the result is taken.
// Reset (synchronous, active low) empties both registers, returns the
// button to released with cleared counters and no stuck flag, and restores
// the configuration registers to their default values.
module adc_button_debounce_stuck_detect #(
    parameter int ADC_BITS  = adcbd_pkg::ADC_BITS_DEF,
    parameter int TIME_BITS = adcbd_pkg::TIME_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    adcbd_sample_if.sink                                          i_sample,
    adcbd_result_if.source                                        o_result,
    input  logic                                                  i_cfg_we,
    input  logic [1:0]                                            i_cfg_idx,
    input  logic [(ADC_BITS > TIME_BITS ? ADC_BITS : TIME_BITS)-1:0] i_cfg_data
);
    import adcbd_pkg::*;

    // Configuration registers.
    logic [ADC_BITS-1:0]  r_pressed_thr;
    logic [ADC_BITS-1:0]  r_released_thr;
    logic [DBNC_BITS-1:0] r_debounce;
    logic [TIME_BITS-1:0] r_stuck_limit;

    logic                take;
    logic                in_valid;
    logic [ADC_BITS-1:0] in_sample;

    // Register writes keep only each register's own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_thr  <= ADC_BITS'(RST_PRESSED_THR);
            r_released_thr <= ADC_BITS'(RST_RELEASED_THR);
            r_debounce     <= DBNC_BITS'(RST_DEBOUNCE);
            r_stuck_limit  <= TIME_BITS'(RST_STUCK_LIMIT);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PRESSED_THR:  r_pressed_thr  <= i_cfg_data[ADC_BITS-1:0];
                CFG_RELEASED_THR: r_released_thr <= i_cfg_data[ADC_BITS-1:0];
                CFG_DEBOUNCE:     r_debounce     <= i_cfg_data[DBNC_BITS-1:0];
                CFG_STUCK_LIMIT:  r_stuck_limit  <= i_cfg_data[TIME_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    adcbd_in_reg #(
        .ADC_BITS (ADC_BITS)
    ) u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_take   (take),
        .o_valid  (in_valid),
        .o_sample (in_sample)
    );

    // Classification, debounce state and result register.
    adcbd_eval #(
        .ADC_BITS  (ADC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .i_sample       (in_sample),
        .i_pressed_thr  (r_pressed_thr),
        .i_released_thr (r_released_thr),
        .i_debounce     (r_debounce),
        .i_stuck_limit  (r_stuck_limit),
        .o_take         (take),
        .o_result       (o_result)
    );
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import adcbd_pkg::*;

    localparam int ADC_W   = ADC_BITS_DEF;
    localparam int TIME_W  = TIME_BITS_DEF;
    localparam int CFG_W   = (ADC_W > TIME_W) ? ADC_W : TIME_W;
    localparam int ADC_MAX = (1 << ADC_W) - 1;
    localparam int WDOG_LIMIT = 3000;
    localparam int LONG_STALL = 80;

    // Kind of reading wanted when building sample sequences.
    typedef enum int {
        CLS_RELEASED,
        CLS_PRESSED,
        CLS_BAND
    } t_cls;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    adcbd_sample_if #(.ADC_BITS(ADC_W)) smp_if ();
    adcbd_result_if                     res_if ();

    adc_button_debounce_stuck_detect #(
        .ADC_BITS  (ADC_W),
        .TIME_BITS (TIME_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_result   (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Samples waiting to be offered and results still owed by the block.
    logic [ADC_W-1:0] sample_q[$];
    t_result          result_q[$];

    // Button model state and its copy of the configuration.
    bit                btn_pressed;
    logic [3:0]        chg_cnt;
    logic [TIME_W-1:0] ticks;
    bit                stuck;
    logic [ADC_W-1:0]  thr_press;
    logic [ADC_W-1:0]  thr_rel;
    logic [3:0]        dbn_len;
    logic [TIME_W-1:0] stuck_lim;

    int      idle_pct;
    bit      stall_req;
    int      snd_gap;
    int      rcv_gap;
    int      wdog_cnt;
    int      n_err;
    int      n_in;
    int      n_out;
    int      n_cfg;
    int      n_edge;
    int      n_stuck;
    t_result rx_want;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance the button model by one sample and return the result it owes.
    function automatic t_result btn_next(input logic [ADC_W-1:0] s);
        t_result r;
        bit      known;
        bit      rd;
        r.event_code = EV_NONE;
        known = 1'b1;
        rd    = 1'b0;
        // Pressed wins when the thresholds overlap.
        if (s >= thr_press) begin
            rd = 1'b1;
        end else if (s <= thr_rel) begin
            rd = 1'b0;
        end else begin
            known = 1'b0;
        end
        if (known) begin
            if (rd == btn_pressed) begin
                chg_cnt = '0;
                if (ticks != '1) begin
                    ticks++;
                end
            end else begin
                ticks = '0;
                if (chg_cnt < dbn_len) begin
                    chg_cnt++;
                end
                if (chg_cnt >= dbn_len) begin
                    btn_pressed  = rd;
                    chg_cnt      = '0;
                    ticks        = '0;
                    stuck        = 1'b0;
                    r.event_code = rd ? EV_OFF_TO_ON : EV_ON_TO_OFF;
                end
            end
        end
        // A stuck event takes the place of an edge event on the same tick.
        if (!stuck && ticks >= stuck_lim) begin
            stuck        = 1'b1;
            r.event_code = btn_pressed ? EV_STUCK_PRESSED : EV_STUCK_RELEASED;
        end
        r.reported_state = stuck ? ST_UNKNOWN : (btn_pressed ? ST_PRESSED : ST_RELEASED);
        r.stuck_now      = stuck;
        return r;
    endfunction

    // Idle length for either side: none unless drawn at idle_pct, then mostly short, a few long.
    function automatic int draw_gap();
        if ($urandom_range(99, 0) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(9, 0) < 8) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // Random sample of a given kind under the present thresholds.
    function automatic logic [ADC_W-1:0] pick_sample(input t_cls cls);
        int lo;
        int hi;
        lo = int'(thr_rel);
        hi = int'(thr_press);
        case (cls)
            CLS_RELEASED: return ADC_W'($urandom_range(lo, 0));
            CLS_PRESSED:  return ADC_W'($urandom_range(ADC_MAX, hi));
            default: begin
                if (hi > lo + 1) begin
                    return ADC_W'($urandom_range(hi - 1, lo + 1));
                end
                return ADC_W'($urandom_range(ADC_MAX, 0));
            end
        endcase
    endfunction

    // Runs of pressed and released readings with some bounce, mixed with noise.
    task automatic add_runs(input int n);
        int   cnt;
        int   len;
        int   cap;
        int   k;
        t_cls cls;
        cnt = 0;
        cls = CLS_RELEASED;
        while (cnt < n) begin
            if ($urandom_range(4, 0) == 0) begin
                sample_q.push_back(ADC_W'($urandom));
                cnt++;
            end else begin
                if ($urandom_range(3, 0) != 0) begin
                    cls = (cls == CLS_PRESSED) ? CLS_RELEASED : CLS_PRESSED;
                end
                cap = (stuck_lim < 60) ? int'(stuck_lim) : 60;
                // Short runs reach at most one past the debounce count; long ones commit or stick.
                if ($urandom_range(2, 0) == 0) begin
                    len = $urandom_range(int'(dbn_len) + 1, 1);
                end else begin
                    len = $urandom_range(int'(dbn_len) + cap + 3, int'(dbn_len));
                end
                for (k = 0; k < len && cnt < n; k++) begin
                    if ($urandom_range(9, 0) == 0) begin
                        sample_q.push_back(pick_sample(CLS_BAND));
                    end else begin
                        sample_q.push_back(pick_sample(cls));
                    end
                    cnt++;
                end
            end
        end
    endtask

    // Wait until every queued sample has gone in and every result has come out.
    // The check is made at the falling edge, once the driver's updates have settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (sample_q.size() != 0 || result_q.size() != 0 || smp_if.valid) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PRESSED_THR:  thr_press = val[ADC_W-1:0];
            CFG_RELEASED_THR: thr_rel   = val[ADC_W-1:0];
            CFG_DEBOUNCE:     dbn_len   = val[3:0];
            CFG_STUCK_LIMIT:  stuck_lim = val[TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] r,
                           input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] s);
        cfg_write(CFG_PRESSED_THR, p);
        cfg_write(CFG_RELEASED_THR, r);
        cfg_write(CFG_DEBOUNCE, d);
        cfg_write(CFG_STUCK_LIMIT, s);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    // Sample driver: offers the queued samples and feeds accepted ones to the model.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid      <= 1'b0;
            smp_if.adc_sample <= '0;
            snd_gap = 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                result_q.push_back(btn_next(smp_if.adc_sample));
                n_in++;
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (snd_gap > 0) begin
                    snd_gap--;
                    smp_if.valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    smp_if.valid      <= 1'b1;
                    smp_if.adc_sample <= sample_q.pop_front();
                    snd_gap = draw_gap();
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction against the oldest expectation
    // and stalls the block at random, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rcv_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_out++;
                if (result_q.size() == 0) begin
                    $error("result with no sample outstanding: event_code %0d",
                           res_if.event_code);
                    n_err++;
                end else begin
                    rx_want = result_q.pop_front();
                    if (res_if.event_code !== rx_want.event_code) begin
                        $error("event_code: expected %0d, got %0d",
                               rx_want.event_code, res_if.event_code);
                        n_err++;
                    end
                    if (res_if.reported_state !== rx_want.reported_state) begin
                        $error("reported_state: expected %0d, got %0d",
                               rx_want.reported_state, res_if.reported_state);
                        n_err++;
                    end
                    if (res_if.stuck_now !== rx_want.stuck_now) begin
                        $error("stuck_now: expected %0d, got %0d",
                               rx_want.stuck_now, res_if.stuck_now);
                        n_err++;
                    end
                    if (rx_want.event_code == EV_OFF_TO_ON
                            || rx_want.event_code == EV_ON_TO_OFF) begin
                        n_edge++;
                    end else if (rx_want.event_code != EV_NONE) begin
                        n_stuck++;
                    end
                end
            end
            if (stall_req) begin
                stall_req = 1'b0;
                rcv_gap   = LONG_STALL;
            end
            if (rcv_gap > 0) begin
                rcv_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                rcv_gap = draw_gap();
            end
        end
    end

    // Watchdog on cycles in which no transaction completes on either side.
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            wdog_cnt = 0;
        end else begin
            wdog_cnt++;
            if (wdog_cnt >= WDOG_LIMIT) begin
                $display("Timeout after %0d cycles with no transaction.", wdog_cnt);
                $display("adc_button_debounce_stuck_detect: mismatch");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        smp_if.valid     = 1'b0;
        smp_if.adc_sample = '0;
        res_if.ready     = 1'b0;
        idle_pct  = 30;
        stall_req = 1'b0;
        wdog_cnt  = 0;
        n_err     = 0;
        n_in      = 0;
        n_out     = 0;
        n_cfg     = 0;
        n_edge    = 0;
        n_stuck   = 0;

        // Model state and configuration as after reset.
        btn_pressed = 1'b0;
        chg_cnt     = '0;
        ticks       = '0;
        stuck       = 1'b0;
        thr_press   = ADC_W'(RST_PRESSED_THR);
        thr_rel     = ADC_W'(RST_RELEASED_THR);
        dbn_len     = 4'(RST_DEBOUNCE);
        stuck_lim   = TIME_W'(RST_STUCK_LIMIT);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset configuration: threshold edges,
        // a full press and release, band readings and an interrupted change.
        sample_q = '{12'd0, 12'd500, 12'd501, 12'd2999, 12'd3000, 12'd4095, 12'd4095,
                     12'd4095, 12'd4095, 12'd2000, 12'd4095, 12'd0, 12'd0, 12'd2500,
                     12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'hAAA, 12'h555};
        wait_idle();

        // Single-sample debounce with a short stuck limit, no idling at all.
        idle_pct = 0;
        set_cfg(CFG_W'(3000), CFG_W'(500), CFG_W'(1), CFG_W'(8));
        add_runs(60);
        wait_idle();

        // Extreme thresholds, longest debounce and a stuck limit of one. The
        // receiver holds off for a long stretch while samples keep coming.
        idle_pct = 0;
        set_cfg(CFG_W'(ADC_MAX), CFG_W'(0), CFG_W'(15), CFG_W'(1));
        add_runs(60);
        stall_req = 1'b1;
        wait_idle();

        // Zero debounce and zero stuck limit with every reading counted as
        // pressed: the stuck event replaces the edge event on the commit.
        idle_pct = 40;
        set_cfg(CFG_W'(0), CFG_W'(ADC_MAX), CFG_W'(0), CFG_W'(0));
        sample_q = '{12'd0, 12'd4095, 12'd2000, 12'd0};
        add_runs(26);
        wait_idle();

        // Adjacent thresholds, no band; the sender drains fully halfway through.
        idle_pct = 30;
        set_cfg(CFG_W'(2048), CFG_W'(2047), CFG_W'(3), CFG_W'(20));
        add_runs(30);
        wait_idle();
        add_runs(30);
        wait_idle();

        // Oversized write data keeps only the register width; the thresholds
        // overlap and the stuck limit is at its maximum.
        idle_pct = 50;
        set_cfg(20'hFF3E8, 20'hABBB8, 20'hFFFF2, 20'hFFFFF);
        add_runs(50);
        wait_idle();

        // A few random settings.
        repeat (3) begin
            idle_pct = $urandom_range(60, 0);
            thr_rel  = ADC_W'($urandom_range(3000, 0));
            set_cfg(CFG_W'($urandom_range(ADC_MAX, int'(thr_rel) + 2)), CFG_W'(thr_rel),
                    CFG_W'($urandom_range(15, 1)), CFG_W'($urandom_range(60, 1)));
            add_runs(50);
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        $display("Ran %0d samples through %0d register settings, %0d results checked.",
                 n_in, n_cfg, n_out);
        $display("Saw %0d debounced edges and %0d stuck events; %0d errors.",
                 n_edge, n_stuck, n_err);
        if (n_err == 0) begin
            $display("adc_button_debounce_stuck_detect: match");
        end else begin
            $display("adc_button_debounce_stuck_detect: mismatch");
        end
        $finish;
    end

endmodule
